[hdl/rrjs_pkg.sv]
// Shared types, constants and helpers of the round-robin job scheduler.
`timescale 1ns / 1ps
package rrjs_pkg;

	// Job queue geometry
	localparam int QUEUE_DEPTH = 256;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Command queue between front and back
	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

	// Field widths
	localparam int ID_W    = 16;
	localparam int TIME_W  = 16;
	localparam int QUANT_W = 8;

	localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(50);

	// Operation codes on the op port
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		ADD_QUEUED   = 2'd0,
		ADD_REJECTED = 2'd1,
		ADD_RETIRED  = 2'd2,
		ADD_NONE     = 2'd3
	} add_status_t;

	// Command kinds decided by the front
	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_ADD_ZERO = 2'd1,
		CMD_TICK     = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] jtime;
	} cmd_t;

	// Advance a circular queue pointer
	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
		else r = p + 1'b1;
		return r;
	endfunction

endpackage

[hdl/round_robin_job_scheduler_top.sv]
// Top level of the round-robin time-slice job scheduler.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive op, job_id and job_units with start high; the beat
//   is taken at a clock edge where start is high and busy is low. op 0 adds a
//   job at the queue tail, op 1 serves the head job for one time unit.
//   Result channel: every beat yields exactly one result, shown for one cycle
//   with res_valid high. The receiver cannot stall; results must be taken.
//   Config: quantum_we with quantum_wdata sets the per-turn quantum; write
//   only while no beat is outstanding.
//   Timing: a two-entry command queue sits ahead of the sequencer. An add
//   completes in ST_IDLE as it is popped; a tick on a non-empty queue passes
//   through ST_IDLE (head read from the job memory) and then ST_EXEC (update
//   and write back). Results are registered. Adds are popped one per cycle
//   while no tick holds the sequencer in ST_EXEC; a tick blocks new commands
//   until its update is written back in ST_EXEC.
//   Reset: clears the queue pointers, the job count and the slice state, and
//   loads a quantum of 50. Job memory contents are not cleared.
module round_robin_job_scheduler_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic [15:0]                job_id,
	input  logic [15:0]                job_units,
	input  logic                       quantum_we,
	input  logic [7:0]                 quantum_wdata,
	output logic                       res_valid,
	output logic [1:0]                 add_status,
	output logic                       busy_res,
	output logic [15:0]                served_id,
	output logic                       served_done,
	output logic                       rotated,
	output logic [rrjs_pkg::CNT_W-1:0] queue_count
);
	import rrjs_pkg::*;

	logic               q_full, q_empty, push, pop;
	cmd_t               cmd_front, cmd_back;
	logic [QUANT_W-1:0] quantum_q;

	// Quantum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RESET;
		end else if (quantum_we) begin
			quantum_q <= quantum_wdata;
		end
	end

	rrjs_front u_front (
		.start     (start),
		.op        (op),
		.job_id    (job_id),
		.job_units (job_units),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.cmd       (cmd_front)
	);

	rrjs_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_front),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.cmd_out (cmd_back)
	);

	rrjs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.quantum     (quantum_q),
		.q_empty     (q_empty),
		.cmd         (cmd_back),
		.pop         (pop),
		.res_valid   (res_valid),
		.add_status  (add_status),
		.busy_res    (busy_res),
		.served_id   (served_id),
		.served_done (served_done),
		.rotated     (rotated),
		.queue_count (queue_count)
	);
endmodule

[hdl/rrjs_front.sv]
// Front end: accepts beats and classifies them into scheduler commands.
`timescale 1ns / 1ps
module rrjs_front (
	input  logic                   start,
	input  logic                   op,
	input  logic [15:0]            job_id,
	input  logic [15:0]            job_units,
	input  logic                   q_full,
	output logic                   busy,
	output logic                   push,
	output rrjs_pkg::cmd_t         cmd
);
	import rrjs_pkg::*;

	// Hold off new beats while the command queue is full
	assign busy = q_full;
	assign push = start & ~q_full;

	// Classify the beat
	always_comb begin
		cmd.id    = job_id;
		cmd.jtime = job_units;
		if (op == OP_TICK) begin
			cmd.kind = CMD_TICK;
		end else if (job_units == '0) begin
			cmd.kind = CMD_ADD_ZERO;
		end else begin
			cmd.kind = CMD_ADD;
		end
	end
endmodule

[hdl/rrjs_cmd_fifo.sv]
// Short command queue that decouples the front from the back.
`timescale 1ns / 1ps
module rrjs_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rrjs_pkg::cmd_t cmd_in,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output rrjs_pkg::cmd_t cmd_out
);
	import rrjs_pkg::*;

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;

	function automatic logic [CMDQ_PTR_W-1:0] bump(input logic [CMDQ_PTR_W-1:0] p);
		logic [CMDQ_PTR_W-1:0] r;
		if (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) r = '0;
		else r = p + 1'b1;
		return r;
	endfunction

	assign full    = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign cmd_out = slot_q[rd_ptr_q];

	// Store pushed beats
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

[hdl/rrjs_back.sv]
// Back end: job queue memory and the add / tick sequencer.
`timescale 1ns / 1ps
module rrjs_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  quantum,
	input  logic                        q_empty,
	input  rrjs_pkg::cmd_t              cmd,
	output logic                        pop,
	output logic                        res_valid,
	output logic [1:0]                  add_status,
	output logic                        busy_res,
	output logic [15:0]                 served_id,
	output logic                        served_done,
	output logic                        rotated,
	output logic [rrjs_pkg::CNT_W-1:0]  queue_count
);
	import rrjs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	// Job queue memory
	logic [ID_W-1:0]   id_mem  [QUEUE_DEPTH];
	logic [TIME_W-1:0] rem_mem [QUEUE_DEPTH];
	logic [ID_W-1:0]   rd_id_q;
	logic [TIME_W-1:0] rd_rem_q;

	logic [PTR_W-1:0]   head_q, tail_q;
	logic [CNT_W-1:0]   count_q;
	logic [QUANT_W-1:0] slice_left_q;
	logic               slice_loaded_q;

	// Result registers
	logic               res_valid_q;
	add_status_t        status_q;
	logic               busy_res_q;
	logic [ID_W-1:0]    sid_q;
	logic               done_q;
	logic               rot_q;

	// Memory write port
	logic               mem_we, id_we;
	logic [PTR_W-1:0]   mem_addr;
	logic [ID_W-1:0]    id_wdata;
	logic [TIME_W-1:0]  rem_wdata;

	// Tick arithmetic
	logic [QUANT_W-1:0] q_eff, slice_base, slice_next;
	logic [TIME_W-1:0]  rem_next;
	logic               fin, rot;
	logic               full;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign pop  = (state_q == ST_IDLE) && !q_empty;

	// Serve one unit of the head job
	always_comb begin
		q_eff = (quantum == '0) ? QUANT_W'(1) : quantum;
		if (slice_loaded_q) begin
			slice_base = slice_left_q;
		end else if (rd_rem_q < {{(TIME_W-QUANT_W){1'b0}}, q_eff}) begin
			slice_base = rd_rem_q[QUANT_W-1:0];
		end else begin
			slice_base = q_eff;
		end
		rem_next   = (rd_rem_q != '0) ? rd_rem_q - 1'b1 : rd_rem_q;
		slice_next = (slice_base != '0) ? slice_base - 1'b1 : slice_base;
		fin        = (rem_next == '0);
		rot        = !fin && (slice_next == '0);
	end

	// Select the memory write
	always_comb begin
		mem_we    = 1'b0;
		id_we     = 1'b0;
		mem_addr  = tail_q;
		id_wdata  = cmd.id;
		rem_wdata = cmd.jtime;
		if (pop && cmd.kind == CMD_ADD && !full) begin
			mem_we = 1'b1;
			id_we  = 1'b1;
		end else if (state_q == ST_EXEC && !fin) begin
			mem_we    = 1'b1;
			rem_wdata = rem_next;
			if (rot) begin
				id_we    = 1'b1;
				id_wdata = rd_id_q;
			end else begin
				mem_addr = head_q;
			end
		end
	end

	// Write the memory and read the head entry
	always_ff @(posedge clk) begin
		if (mem_we) rem_mem[mem_addr] <= rem_wdata;
		if (id_we)  id_mem[mem_addr]  <= id_wdata;
		rd_id_q  <= id_mem[head_q];
		rd_rem_q <= rem_mem[head_q];
	end

	// Sequence commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			head_q         <= '0;
			tail_q         <= '0;
			count_q        <= '0;
			slice_left_q   <= '0;
			slice_loaded_q <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (cmd.kind == CMD_TICK && count_q != '0) begin
							state_q <= ST_EXEC;
						end else begin
							res_valid_q <= 1'b1;
							if (cmd.kind == CMD_ADD && !full) begin
								tail_q  <= next_slot(tail_q);
								count_q <= count_q + 1'b1;
							end
						end
					end
				end
				ST_EXEC: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
					if (fin) begin
						head_q         <= next_slot(head_q);
						count_q        <= count_q - 1'b1;
						slice_loaded_q <= 1'b0;
						slice_left_q   <= '0;
					end else if (rot) begin
						head_q         <= next_slot(head_q);
						tail_q         <= next_slot(tail_q);
						slice_loaded_q <= 1'b0;
						slice_left_q   <= slice_next;
					end else begin
						slice_loaded_q <= 1'b1;
						slice_left_q   <= slice_next;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			status_q   <= ADD_NONE;
			busy_res_q <= 1'b1;
			sid_q      <= rd_id_q;
			done_q     <= fin;
			rot_q      <= rot;
		end else if (pop) begin
			busy_res_q <= 1'b0;
			done_q     <= 1'b0;
			rot_q      <= 1'b0;
			unique case (cmd.kind)
				CMD_ADD: begin
					status_q <= full ? ADD_REJECTED : ADD_QUEUED;
					sid_q    <= cmd.id;
				end
				CMD_ADD_ZERO: begin
					status_q <= ADD_RETIRED;
					sid_q    <= cmd.id;
				end
				CMD_TICK: begin
					status_q <= ADD_NONE;
					sid_q    <= '0;
				end
				default: begin
					status_q <= ADD_NONE;
					sid_q    <= '0;
				end
			endcase
		end
	end

	assign res_valid   = res_valid_q;
	assign add_status  = status_q;
	assign busy_res    = busy_res_q;
	assign served_id   = sid_q;
	assign served_done = done_q;
	assign rotated     = rot_q;
	assign queue_count = count_q;
endmodule
